[hdl/tes_pkg.sv]
// Package for the timed event scheduler: opcodes, constants, controller states,
// and the command/status structs that pass between the controller and the datapath.
// No dependencies.
package tes_pkg;

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_RUN      = 1'b1;

    localparam logic [31:0] SIGN32  = 32'h8000_0000;
    localparam logic [31:0] MAXDIFF = 32'h7fff_ffff;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED_ADD,
        ST_SCHED_UPD,
        ST_PEND_SCAN,
        ST_PEND_SET,
        ST_FIRE_SCAN,
        ST_FIRE_DECIDE,
        ST_EMIT_LAST
    } tes_state_t;

    typedef struct packed {
        logic capture;      // latch the input beat
        logic scan_clear;   // restart the slot scan
        logic scan_step;    // compare one slot
        logic scan_fire;    // scan mode: 1 fire round, 0 pending-only
        logic sched_add;    // due = (now + delay) | 1
        logic sched_upd;    // write slot, lower next-due
        logic set_next;     // next-due from pending scan
        logic emit_fired;   // load fired result, clear slot
        logic emit_last;    // load closing result
    } tes_cmd_t;

    typedef struct packed {
        logic scan_last;    // current scan index is the last slot
        logic fire_now;     // best slot of last scan is due
        logic out_free;     // output register can take a beat
    } tes_status_t;

endpackage

[hdl/tes_controller.sv]
// Controller state machine of the timed event scheduler.
// Depends on tes_pkg (state enum, command and status structs).
module tes_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_op,
    output logic                 in_ready,
    output tes_pkg::tes_cmd_t    cmd,
    input  tes_pkg::tes_status_t status
);
    import tes_pkg::*;

    tes_state_t state_reg;
    tes_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture    = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = (in_op == OP_RUN) ? ST_PEND_SCAN : ST_SCHED_ADD;
                end
            end
            ST_SCHED_ADD:
            begin
                cmd.sched_add = 1'b1;
                state_next    = ST_SCHED_UPD;
            end
            ST_SCHED_UPD:
            begin
                cmd.sched_upd = 1'b1;
                state_next    = ST_EMIT_LAST;
            end
            ST_PEND_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_PEND_SET;
                end
            end
            ST_PEND_SET:
            begin
                cmd.set_next   = 1'b1;
                cmd.scan_clear = 1'b1;
                state_next     = ST_FIRE_SCAN;
            end
            ST_FIRE_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.scan_fire = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_FIRE_DECIDE;
                end
            end
            ST_FIRE_DECIDE:
            begin
                if (!status.fire_now)
                begin
                    state_next = ST_EMIT_LAST;
                end
                else if (status.out_free)
                begin
                    cmd.emit_fired = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_FIRE_SCAN;
                end
            end
            ST_EMIT_LAST:
            begin
                if (status.out_free)
                begin
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/tes_datapath.sv]
// Datapath of the timed event scheduler: slot due times, next-due cache,
// one-slot-per-cycle min-difference scan and the output register.
// Depends on tes_pkg (constants, command and status structs).
module tes_datapath #(
    parameter int EVENT_SLOTS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tes_pkg::tes_cmd_t     cmd,
    output tes_pkg::tes_status_t  status,
    input  logic [1:0]            in_slot_id,
    input  logic [31:0]           in_time_now,
    input  logic [30:0]           in_delay,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_fired,
    output logic [1:0]            out_fired_slot,
    output logic [31:0]           out_fired_time,
    output logic [31:0]           out_next_due,
    output logic                  out_last
);
    import tes_pkg::*;

    localparam int SLOT_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

    logic [1:0]        slot_reg;
    logic [31:0]       now_reg;
    logic [30:0]       delay_reg;
    logic [31:0]       when_reg;
    logic [31:0]       due_reg [EVENT_SLOTS];
    logic [31:0]       next_due_reg;
    logic [SLOT_W-1:0] scan_cnt_reg;
    logic              best_found_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [31:0]       best_diff_reg;
    logic [31:0]       best_due_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_fired_reg;
    logic [1:0]        out_slot_reg;
    logic [31:0]       out_time_reg;
    logic [31:0]       out_next_reg;
    logic              out_last_reg;

    logic [31:0] scan_due;
    logic [31:0] scan_diff;
    logic        scan_less;
    logic        scan_pos;
    logic        scan_take;
    logic        scan_last;
    logic        slot_in_range;
    logic [31:0] cache_diff;
    logic        cache_later;
    logic        out_load;

    // scan compare: signed (due - now) against the best so far
    assign scan_due  = due_reg[scan_cnt_reg];
    assign scan_diff = scan_due - now_reg;
    assign scan_less = (scan_diff ^ SIGN32) < (best_diff_reg ^ SIGN32);
    assign scan_pos  = (scan_diff != 32'd0) && !scan_diff[31];
    assign scan_take = (scan_due != 32'd0) && scan_less && (cmd.scan_fire || scan_pos);
    assign scan_last = (scan_cnt_reg == SLOT_W'(EVENT_SLOTS - 1));

    assign slot_in_range = (32'(slot_reg) < 32'(EVENT_SLOTS));
    assign cache_diff    = next_due_reg - when_reg;
    assign cache_later   = (cache_diff != 32'd0) && !cache_diff[31];

    assign out_load = cmd.emit_fired || cmd.emit_last;

    always_comb
    begin
        status.scan_last = scan_last;
        status.fire_now  = best_found_reg && ((best_diff_reg == 32'd0) || best_diff_reg[31]);
        status.out_free  = !out_valid_reg || out_ready;
    end

    // input capture and due-time sum (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg  <= in_slot_id;
            now_reg   <= in_time_now;
            delay_reg <= in_delay;
        end
        if (cmd.sched_add)
        begin
            when_reg <= (now_reg + {1'b0, delay_reg}) | 32'd1;
        end
    end

    // slot store and next-due cache
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < EVENT_SLOTS; i++)
            begin
                due_reg[i] <= 32'd0;
            end
            next_due_reg <= 32'd0;
        end
        else
        begin
            for (int i = 0; i < EVENT_SLOTS; i++)
            begin
                if (cmd.sched_upd && slot_in_range && (32'(slot_reg) == 32'(i)))
                begin
                    due_reg[i] <= when_reg;
                end
                else if (cmd.emit_fired && (best_idx_reg == SLOT_W'(i)))
                begin
                    due_reg[i] <= 32'd0;
                end
            end
            if (cmd.sched_upd && slot_in_range && ((next_due_reg == 32'd0) || cache_later))
            begin
                next_due_reg <= when_reg;
            end
            else if (cmd.set_next)
            begin
                next_due_reg <= best_found_reg ? best_due_reg : 32'd0;
            end
        end
    end

    // scan counter and best candidate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg   <= '0;
            best_found_reg <= 1'b0;
            best_diff_reg  <= MAXDIFF;
        end
        else if (cmd.scan_clear)
        begin
            scan_cnt_reg   <= '0;
            best_found_reg <= 1'b0;
            best_diff_reg  <= MAXDIFF;
        end
        else if (cmd.scan_step)
        begin
            scan_cnt_reg <= scan_last ? '0 : scan_cnt_reg + SLOT_W'(1);
            if (scan_take)
            begin
                best_found_reg <= 1'b1;
                best_diff_reg  <= scan_diff;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && scan_take)
        begin
            best_idx_reg <= scan_cnt_reg;
            best_due_reg <= scan_due;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // next_due is final for the whole step before any result is loaded
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_fired_reg <= cmd.emit_fired;
            out_slot_reg  <= cmd.emit_fired ? 2'(best_idx_reg) : 2'd0;
            out_time_reg  <= cmd.emit_fired ? best_due_reg : 32'd0;
            out_next_reg  <= next_due_reg;
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_fired      = out_fired_reg;
    assign out_fired_slot = out_slot_reg;
    assign out_fired_time = out_time_reg;
    assign out_next_due   = out_next_reg;
    assign out_last       = out_last_reg;

endmodule

[hdl/timed_event_scheduler_unit.sv]
// Top level of the timed event scheduler: stream ports, controller and datapath.
// Depends on tes_pkg, tes_controller and tes_datapath.
//
// Channel | Dir | Beat contents
// --------+-----+-----------------------------------------------------------------
// s_*     | in  | tuser: operation; tdata: slot_id, time_now, delay
// m_*     | out | tuser: fired; tdata: fired_slot, fired_time, next_due; tlast: last
//
// Steps: a schedule beat forms its due time, writes the slot and then loads its result;
// the next beat is taken only after that result is loaded. A run beat with N slots
// makes a pending-only pass to set the next-due cache, then one fire pass per fired
// event plus a final pass that finds none, then loads its closing result; one shared
// subtract-and-compare unit looks at one slot per cycle in every pass.
// Reset: rst_n clears all slots to idle, the next-due cache to zero and the output valid flag.
// Stalls: m_tready low holds the result register; the next result waits for it,
// while s_tready rises again once the previous item's last result is loaded.
module timed_event_scheduler_unit #(
    parameter int EVENT_SLOTS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] slot_id, [33:2] time_now, [64:34] delay, rest 0
    input  logic [tes_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,   // [0] operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] fired_slot, [33:2] fired_time, [65:34] next_due, rest 0
    output logic [tes_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tuser,   // [0] fired
    output logic                           m_tlast
);
    import tes_pkg::*;

    tes_cmd_t    cmd;
    tes_status_t status;

    logic [1:0]  fired_slot;
    logic [31:0] fired_time;
    logic [31:0] next_due;

    tes_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    tes_datapath #(
        .EVENT_SLOTS (EVENT_SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_slot_id     (s_tdata[1:0]),
        .in_time_now    (s_tdata[33:2]),
        .in_delay       (s_tdata[64:34]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_fired      (m_tuser),
        .out_fired_slot (fired_slot),
        .out_fired_time (fired_time),
        .out_next_due   (next_due),
        .out_last       (m_tlast)
    );

    assign m_tdata = {6'd0, next_due, fired_time, fired_slot};

    // upper input pad bits carry nothing
    logic [6:0] unused_pad;
    assign unused_pad = s_tdata[71:65];

    // a fired beat never closes the step
    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tlast)
        else $error("fired beat flagged last");

    // a fired due time always has bit 0 set
    a_fired_time_odd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[2])
        else $error("fired beat with idle due time");

    // non-fired beats carry zero slot and time
    a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[33:0] == 34'd0))
        else $error("non-fired beat with slot or time set");

    // one item at a time: no acceptance right after an acceptance
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

endmodule

[bench/timed_event_scheduler_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for timed_event_scheduler_unit: directed and random schedule/run beats,
// an in-bench deadline-queue predictor and a stream scoreboard. Depends on tes_pkg and the RTL.
module timed_event_scheduler_unit_test;
    import tes_pkg::*;

    localparam int SLOTS       = 4;
    localparam int RANDOM_ITEMS = 80;
    localparam int STALL_LIMIT = 2000;   // cycles without any beat before giving up
    localparam int DRAIN_WAIT  = 48;     // longer than the worst-case run item

    typedef struct packed {
        logic        op;
        logic [1:0]  slot;
        logic [31:0] now;
        logic [30:0] delay;
    } sched_item_t;

    typedef struct packed {
        logic        fired;
        logic [1:0]  slot;
        logic [31:0] when;
        logic [31:0] next_due;
        logic        last;
    } due_report_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;   // [1:0] slot_id, [33:2] time_now, [64:34] delay, rest 0
    logic        s_tuser  = 1'b0; // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // [1:0] fired_slot, [33:2] fired_time, [65:34] next_due
    logic        m_tuser;         // [0] fired
    logic        m_tlast;

    sched_item_t item_q[$];        // beats waiting to be driven
    sched_item_t drive_item = '0;  // beat currently on the slave port
    due_report_t pending_reports[$];

    // predictor state
    logic [31:0] slot_due[SLOTS];
    logic [31:0] cached_next_due = '0;

    logic beat_taken     = 1'b0;
    bit   mismatch_seen  = 1'b0;
    int   beats_in       = 0;
    int   beats_out      = 0;
    int   quiet_cycles   = 0;

    timed_event_scheduler_unit #(.EVENT_SLOTS(SLOTS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            slot_due[i] = '0;
    end

    // Applies one accepted beat to the predicted slot table and queues the
    // reports it should produce. Every report of a step carries the next-due
    // value that holds after the whole step.
    function automatic void advance_deadline_queue(sched_item_t it);
        due_report_t step_reports[$];
        due_report_t r;
        logic [31:0] when;
        logic [31:0] d;
        logic [31:0] best_diff;
        int          best;
        bit          searching;
        r = '0;
        if (it.op == OP_SCHEDULE)
        begin
            when = (it.now + {1'b0, it.delay}) | 32'd1;
            if (int'(it.slot) < SLOTS)
            begin
                slot_due[it.slot] = when;
                d = cached_next_due - when;
                // only lowered here; a run recomputes it
                if (cached_next_due == '0 || (d != '0 && !d[31]))
                    cached_next_due = when;
            end
        end
        else
        begin
            searching = 1'b1;
            while (searching)
            begin
                best = -1;
                best_diff = MAXDIFF;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_due[i] != '0)
                    begin
                        d = slot_due[i] - it.now;
                        // strict compare: lowest index wins ties, and a slot
                        // exactly MAXDIFF ahead is never picked
                        if ($signed(d) < $signed(best_diff))
                        begin
                            best_diff = d;
                            best = i;
                        end
                    end
                end
                if (best >= 0 && (best_diff == '0 || best_diff[31]))
                begin
                    r.fired = 1'b1;
                    r.slot  = best[1:0];
                    r.when  = slot_due[best];
                    r.last  = 1'b0;
                    step_reports.push_back(r);
                    slot_due[best] = '0;
                end
                else
                begin
                    cached_next_due = (best >= 0) ? slot_due[best] : '0;
                    searching = 1'b0;
                end
            end
        end
        r = '0;
        r.last = 1'b1;
        step_reports.push_back(r);
        foreach (step_reports[k])
        begin
            step_reports[k].next_due = cached_next_due;
            pending_reports.push_back(step_reports[k]);
        end
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatch_seen = 1'b1;
        end
    endtask

    // Beat accounting, prediction and checking, all on the rising edge.
    always @(posedge clk)
    begin
        due_report_t exp_rep;
        beat_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                advance_deadline_queue(drive_item);
                beats_in <= beats_in + 1;
            end
            if (m_tvalid && m_tready)
            begin
                beats_out <= beats_out + 1;
                if (pending_reports.size() == 0)
                begin
                    $error("unexpected result beat: fired=%0b slot=%0d time=0x%0h",
                           m_tuser, m_tdata[1:0], m_tdata[33:2]);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    exp_rep = pending_reports.pop_front();
                    compare_field("fired", 32'(exp_rep.fired), 32'(m_tuser));
                    compare_field("fired_slot", 32'(exp_rep.slot), 32'(m_tdata[1:0]));
                    compare_field("fired_time", exp_rep.when, m_tdata[33:2]);
                    compare_field("next_due", exp_rep.next_due, m_tdata[65:34]);
                    compare_field("last", 32'(exp_rep.last), 32'(m_tlast));
                end
            end
        end
    end

    // Driver: changes inputs on the falling edge. Roughly 13% idle on each side,
    // with a gap-free stretch in the middle of the run.
    always @(negedge clk)
    begin
        bit src_gap;
        bit snk_gap;
        src_gap = ($urandom_range(0, 99) < 13) && !(beats_in >= 45 && beats_in < 75);
        snk_gap = ($urandom_range(0, 99) < 13) && !(beats_out >= 60 && beats_out < 110);
        if (rst_n)
        begin
            if (!s_tvalid || beat_taken)
            begin
                if (item_q.size() > 0 && !src_gap)
                begin
                    drive_item <= item_q[0];
                    s_tdata    <= {7'b0, item_q[0].delay, item_q[0].now, item_q[0].slot};
                    s_tuser    <= item_q[0].op;
                    s_tvalid   <= 1'b1;
                    void'(item_q.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !snk_gap;
        end
    end

    // Watchdog: any accepted beat on either side resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timed_event_scheduler_unit regression: fail");
                $finish;
            end
        end
    end

    function automatic void add_item(logic op, logic [1:0] slot, logic [31:0] now,
                                     logic [30:0] delay);
        sched_item_t it;
        it.op    = op;
        it.slot  = slot;
        it.now   = now;
        it.delay = delay;
        item_q.push_back(it);
    endfunction

    initial
    begin
        logic [31:0] run_clock;
        logic [31:0] now;
        logic [30:0] delay;
        int          pick;

        // directed part
        add_item(OP_RUN, 2'd0, 32'h0000_0000, 31'd0);                 // empty queue
        add_item(OP_SCHEDULE, 2'd0, 32'h0000_0000, 31'h7fff_fffe);    // due 0x7fffffff
        add_item(OP_RUN, 2'd3, 32'h0000_0000, 31'h7fff_ffff);         // exactly MAXDIFF ahead
        add_item(OP_RUN, 2'd0, 32'h7fff_ffff, 31'd0);                 // now it fires
        add_item(OP_SCHEDULE, 2'd0, 32'h0000_0000, 31'd0);            // bit 0 forced
        add_item(OP_SCHEDULE, 2'd2, 32'hffff_fff0, 31'h11);           // wraps to 1, tie
        add_item(OP_SCHEDULE, 2'd1, 32'hffff_ffff, 31'h7fff_ffff);    // max fields
        add_item(OP_SCHEDULE, 2'd3, 32'h1234_5678, 31'h2aaa_aaaa);
        add_item(OP_SCHEDULE, 2'd3, 32'h0000_0004, 31'd10);           // reschedule busy slot
        add_item(OP_RUN, 2'd1, 32'h0000_0001, 31'd0);                 // tie: slot 0 then 2
        add_item(OP_RUN, 2'd0, 32'h8000_0000, 31'd0);
        for (int i = 0; i < SLOTS; i++)
            add_item(OP_SCHEDULE, i[1:0], 32'haaaa_aaaa, 31'h5555_5555);
        add_item(OP_RUN, 2'd2, 32'hffff_ffff, 31'h5555_5555);         // all four fire
        add_item(OP_SCHEDULE, 2'd2, 32'h5555_5555, 31'h2aaa_aaaa);
        add_item(OP_SCHEDULE, 2'd1, 32'hffff_fffe, 31'd1);
        add_item(OP_RUN, 2'd0, 32'h5555_5554, 31'd0);
        add_item(OP_RUN, 2'd0, 32'h7fff_ffff, 31'd0);
        add_item(OP_RUN, 2'd0, 32'hffff_ffff, 31'd0);

        // random part: mostly schedule/run traffic around a moving clock, with
        // some wide delays, clock jumps and fully random beats mixed in
        run_clock = $urandom();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 55)
            begin
                now = run_clock + $urandom_range(0, 20);
                case ($urandom_range(0, 9))
                    0:       delay = 31'($urandom());
                    1:       delay = 31'h7fff_ffff - 31'($urandom_range(0, 3));
                    default: delay = 31'($urandom_range(0, 200));
                endcase
                add_item(OP_SCHEDULE, 2'($urandom_range(0, SLOTS - 1)), now, delay);
            end
            else if (pick < 90)
            begin
                run_clock = run_clock + $urandom_range(0, 150);
                add_item(OP_RUN, 2'($urandom_range(0, 3)), run_clock, 31'($urandom()));
            end
            else if (pick < 93)
            begin
                run_clock = $urandom();
            end
            else
            begin
                add_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom(),
                         31'($urandom()));
            end
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        while (item_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (pending_reports.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_reports.size());
            mismatch_seen = 1'b1;
        end
        if (!mismatch_seen)
            $display("timed_event_scheduler_unit regression: pass");
        else
            $display("timed_event_scheduler_unit regression: fail");
        $finish;
    end

endmodule
